@@ hdl/efgu_pkg.sv @@
package efgu_pkg;

   localparam int TASKS  = 8;
   localparam int GROUPS = 4;
   localparam int TASK_W = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // Operation codes.
   localparam logic [1:0] FN_CREATE = 2'd0;
   localparam logic [1:0] FN_PEND   = 2'd1;
   localparam logic [1:0] FN_POST   = 2'd2;
   localparam logic [1:0] FN_DELETE = 2'd3;

   // Result status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_NO_FREE = 2'd2;

   // Requested wait modes.
   localparam logic [1:0] REQ_MODE_ALL = 2'd0;
   localparam logic [1:0] REQ_MODE_ANY = 2'd1;

   // Stored wait modes; code 3 never arises and reads as not pending.
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_ALL  = 2'd1;
   localparam logic [1:0] MODE_ANY  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  group;
      logic [2:0]  task_req;
      logic [15:0] flag_bits;
      logic [1:0]  wait_mode;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  group_id;
      logic [7:0]  woken_tasks;
      logic [15:0] flags_now;
   } rsp_type;

   typedef struct packed {
      logic        wake;
      logic [15:0] flags_next;
   } eval_type;

endpackage

@@ hdl/efgu_task_eval.sv @@
// Tests one waiting task against a group's flags and works out the
// flags left after the task consumes its matched bits.
module efgu_task_eval (
   input  logic [1:0]          mode,
   input  logic [15:0]         want,
   input  logic [15:0]         flags,
   output efgu_pkg::eval_type  result
);

   logic [15:0] hit;

   assign hit = flags & want;

   always_comb begin
      case (mode)
         efgu_pkg::MODE_ALL: result.wake = (hit == want);
         efgu_pkg::MODE_ANY: result.wake = (hit != 16'd0);
         default:            result.wake = 1'b0;
      endcase
      result.flags_next = result.wake ? (flags & ~hit) : flags;
   end

endmodule

@@ hdl/event_flag_group_unit.sv @@
// Event flag group unit. It keeps GROUPS flag groups of 16 bits, a taken bit
// per group, a wait mode per group and task, and a wait mask per task, and
// serves create, pend, post and delete requests with one response each.
// Create, pend, delete and every rejected request go from the idle state
// straight to the done state, which loads the response register. A valid
// post sets the flags when the request is taken; then a single shared task
// evaluator visits the tasks in index order from task 0, one per cycle, so
// that bits consumed by a woken task are gone before the next task is
// tested, and the done state then loads the response. The done state waits
// while the output register still holds a stalled response. The unit takes
// one request at a time; the response sits in an output register, so the
// next request is taken as soon as the previous response has been loaded
// there, even while it still waits to be transferred.
module event_flag_group_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  efgu_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output efgu_pkg::rsp_type  rsp_data
);

   localparam logic [efgu_pkg::TASK_W-1:0] LAST_TASK =
      efgu_pkg::TASK_W'(efgu_pkg::TASKS - 1);

   efgu_pkg::state_type state_ff, state_in;

   logic [efgu_pkg::TASK_W-1:0] cnt_ff, cnt_in;
   logic [efgu_pkg::GRP_W-1:0]  g_ff, g_in;

   logic [15:0]                 flags_ff [efgu_pkg::GROUPS];
   logic [15:0]                 flags_in [efgu_pkg::GROUPS];
   logic [efgu_pkg::GROUPS-1:0] used_ff, used_in;
   logic [1:0]                  pend_ff  [efgu_pkg::GROUPS][efgu_pkg::TASKS];
   logic [1:0]                  pend_in  [efgu_pkg::GROUPS][efgu_pkg::TASKS];
   logic [15:0]                 mask_ff  [efgu_pkg::TASKS];
   logic [15:0]                 mask_in  [efgu_pkg::TASKS];

   // Response fields gathered while the request is worked on.
   logic [1:0]                 res_status_ff, res_status_in;
   logic [1:0]                 res_gid_ff, res_gid_in;
   logic [efgu_pkg::TASKS-1:0] woken_ff, woken_in;
   logic [15:0]                res_flags_ff, res_flags_in;

   logic              rsp_valid_ff, rsp_valid_in;
   efgu_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                       req_accept;
   logic                       rsp_load;
   logic                       group_ok;
   logic                       task_ok;
   logic                       post_walk;
   logic [efgu_pkg::GRP_W-1:0] req_g;
   logic [efgu_pkg::TASK_W-1:0] req_t;
   logic                       free_found;
   logic [efgu_pkg::GRP_W-1:0] free_idx;
   efgu_pkg::eval_type         ev;

   assign req_stall  = (state_ff != efgu_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == efgu_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign req_g     = req_data.group[efgu_pkg::GRP_W-1:0];
   assign req_t     = req_data.task_req[efgu_pkg::TASK_W-1:0];
   assign group_ok  = int'(req_data.group) < efgu_pkg::GROUPS;
   assign task_ok   = int'(req_data.task_req) < efgu_pkg::TASKS;
   assign post_walk = (req_data.func == efgu_pkg::FN_POST) && group_ok &&
                      (req_data.flag_bits != 16'd0);

   // Lowest free group for create.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = efgu_pkg::GROUPS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = efgu_pkg::GRP_W'(i);
         end
      end
   end

   // The one evaluator shared by every step of the post walk.
   efgu_task_eval u_eval (
      .mode   (pend_ff[g_ff][cnt_ff]),
      .want   (mask_ff[cnt_ff]),
      .flags  (flags_ff[g_ff]),
      .result (ev)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efgu_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = post_walk ? efgu_pkg::ST_WALK : efgu_pkg::ST_DONE;
            end
         end
         efgu_pkg::ST_WALK: begin
            if (cnt_ff == LAST_TASK) begin
               state_in = efgu_pkg::ST_DONE;
            end
         end
         efgu_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = efgu_pkg::ST_IDLE;
            end
         end
         default: state_in = efgu_pkg::ST_IDLE;
      endcase
   end

   // Datapath and response register.
   always_comb begin
      cnt_in        = cnt_ff;
      g_in          = g_ff;
      flags_in      = flags_ff;
      used_in       = used_ff;
      pend_in       = pend_ff;
      mask_in       = mask_ff;
      res_status_in = res_status_ff;
      res_gid_in    = res_gid_ff;
      woken_in      = woken_ff;
      res_flags_in  = res_flags_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         efgu_pkg::ST_IDLE: begin
            if (req_accept) begin
               res_status_in = efgu_pkg::STAT_OK;
               res_gid_in    = 2'd0;
               woken_in      = '0;
               res_flags_in  = 16'd0;
               g_in          = req_g;
               cnt_in        = '0;
               if (req_data.func == efgu_pkg::FN_CREATE) begin
                  if (free_found) begin
                     used_in[free_idx] = 1'b1;
                     res_gid_in        = 2'(free_idx);
                     res_flags_in      = flags_ff[free_idx];
                  end else begin
                     res_status_in = efgu_pkg::STAT_NO_FREE;
                  end
               end else if (!group_ok) begin
                  res_status_in = efgu_pkg::STAT_INVALID;
               end else begin
                  res_flags_in = flags_ff[req_g];
                  case (req_data.func)
                     efgu_pkg::FN_PEND: begin
                        if (!task_ok || (req_data.wait_mode != efgu_pkg::REQ_MODE_ALL &&
                                         req_data.wait_mode != efgu_pkg::REQ_MODE_ANY)) begin
                           res_status_in = efgu_pkg::STAT_INVALID;
                        end else begin
                           mask_in[req_t] = mask_ff[req_t] | req_data.flag_bits;
                           pend_in[req_g][req_t] =
                              (req_data.wait_mode == efgu_pkg::REQ_MODE_ALL) ?
                              efgu_pkg::MODE_ALL : efgu_pkg::MODE_ANY;
                        end
                     end
                     efgu_pkg::FN_POST: begin
                        if (req_data.flag_bits == 16'd0) begin
                           res_status_in = efgu_pkg::STAT_INVALID;
                        end else begin
                           flags_in[req_g] = flags_ff[req_g] | req_data.flag_bits;
                        end
                     end
                     default: begin
                        for (int t = 0; t < efgu_pkg::TASKS; t++) begin
                           pend_in[req_g][t] = efgu_pkg::MODE_NONE;
                           mask_in[t]        = 16'd0;
                        end
                        used_in[req_g] = 1'b0;
                        woken_in       = '1;
                     end
                  endcase
               end
            end
         end
         efgu_pkg::ST_WALK: begin
            flags_in[g_ff] = ev.flags_next;
            res_flags_in   = ev.flags_next;
            cnt_in         = cnt_ff + 1'b1;
            if (ev.wake) begin
               mask_in[cnt_ff]       = 16'd0;
               pend_in[g_ff][cnt_ff] = efgu_pkg::MODE_NONE;
               woken_in[cnt_ff]      = 1'b1;
            end
         end
         efgu_pkg::ST_DONE: ;
         default: ;
      endcase

      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = res_status_ff;
         rsp_data_in.group_id    = res_gid_ff;
         rsp_data_in.woken_tasks = 8'(woken_ff);
         rsp_data_in.flags_now   = res_flags_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efgu_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
         for (int g = 0; g < efgu_pkg::GROUPS; g++) begin
            flags_ff[g] <= 16'd0;
            for (int t = 0; t < efgu_pkg::TASKS; t++) begin
               pend_ff[g][t] <= efgu_pkg::MODE_NONE;
            end
         end
         for (int t = 0; t < efgu_pkg::TASKS; t++) begin
            mask_ff[t] <= 16'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         flags_ff     <= flags_in;
         pend_ff      <= pend_in;
         mask_ff      <= mask_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      g_ff          <= g_in;
      res_status_ff <= res_status_in;
      res_gid_ff    <= res_gid_in;
      woken_ff      <= woken_in;
      res_flags_ff  <= res_flags_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The walk visits the tasks in order, one per cycle.
   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == efgu_pkg::ST_WALK && cnt_ff != LAST_TASK)
      |=> (state_ff == efgu_pkg::ST_WALK && cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("post walk skipped or stopped early");

   // Only a task that is pending on the group can be woken by the walk.
   a_wake_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == efgu_pkg::ST_WALK && ev.wake)
      |-> (pend_ff[g_ff][cnt_ff] == efgu_pkg::MODE_ALL ||
           pend_ff[g_ff][cnt_ff] == efgu_pkg::MODE_ANY))
      else $error("woke a task that was not waiting");

   // A new response appears only when the sequencer has finished a request.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == efgu_pkg::ST_DONE))
      else $error("response raised outside the done state");

   // A valid post always enters the walk.
   a_post_walks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && post_walk) |=> (state_ff == efgu_pkg::ST_WALK && cnt_ff == '0))
      else $error("post did not start the task walk");

endmodule
